/* rtl/phs_pkg.sv */
// Shared types and constants for the periodic hook scheduler.
// Standalone package; used by every module in rtl/.
`default_nettype none

package phs_pkg;

	localparam int MAX_SLOTS_DEF = 16;
	localparam int MAX_RESULTS   = 16;
	localparam int NRES_W        = $clog2(MAX_RESULTS + 1);
	localparam int S_DATA_W      = 48;
	localparam int M_DATA_W      = 16;

	localparam logic signed [15:0] COUNT_MIN = 16'sh8000;

	typedef enum logic [1:0] {
		CMD_TICK = 2'd0,
		CMD_POLL = 2'd1,
		CMD_REG  = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	// one timer channel
	typedef struct packed {
		logic [14:0]        period;
		logic signed [15:0] count;
		logic               enabled;
		logic               looped;
		logic               on_tick;
		logic [7:0]         ident;
	} slot_t;

	typedef struct packed {
		logic rotate;
		logic insert;
	} cell_ctrl_t;

	typedef struct packed {
		logic fire;
		logic warn;
		logic err;
	} fire_info_t;

endpackage

`default_nettype wire

/* rtl/phs_cell.sv */
// One channel slot of the scheduler chain: holds, rotates toward slot 0, or
// takes part in a sorted insert. Depends on phs_pkg.
`default_nettype none

module phs_cell import phs_pkg::*; #(
	parameter int MAX_SLOTS = MAX_SLOTS_DEF,
	parameter int IDX       = 0
) (
	input  wire logic                           clk,
	input  wire cell_ctrl_t                     ctrl,
	input  wire logic [$clog2(MAX_SLOTS+1)-1:0] used,
	input  wire slot_t                          new_slot,
	input  wire slot_t                          left_slot,
	input  wire logic                           left_ins,
	input  wire slot_t                          right_slot,
	input  wire slot_t                          tail_slot,
	output slot_t                               slot,
	output logic                                ins_here
);

	localparam int UW = $clog2(MAX_SLOTS + 1);

	slot_t slot_q;
	logic  is_tail;

	// insert position: first slot whose period is strictly larger, or the free end
	assign ins_here = (UW'(IDX) >= used) || (slot_q.period > new_slot.period);
	assign is_tail  = (UW'(IDX + 1) == used);
	assign slot     = slot_q;

	always_ff @(posedge clk) begin
		priority if (ctrl.rotate) begin
			slot_q <= is_tail ? tail_slot : right_slot;
		end else if (ctrl.insert && ins_here) begin
			slot_q <= left_ins ? left_slot : new_slot;
		end
	end

endmodule

`default_nettype wire

/* rtl/phs_update.sv */
// Check-and-reload unit applied to the slot leaving the head of the chain.
// Depends on phs_pkg.
`default_nettype none

module phs_update import phs_pkg::*; (
	input  wire slot_t      head,
	input  wire logic       is_tick,
	output slot_t           nxt,
	output fire_info_t      info
);

	logic signed [15:0] c;
	logic               check;

	always_comb begin
		nxt  = head;
		info = '0;
		c    = head.count;
		if (is_tick && head.enabled && (c != COUNT_MIN)) begin
			c = c - 16'sd1;
		end
		check = is_tick ? head.on_tick : head.enabled;
		if (check && (c <= 16'sd0)) begin
			info.fire = 1'b1;
			info.warn = (c < 16'sd0);
			if (!head.looped) begin
				nxt.enabled = 1'b0;
			end
			// count <= 0 and period < 2^15, so the sum stays in range
			c        = c + $signed({1'b0, head.period});
			info.err = (c < 16'sd0);
		end
		nxt.count = c;
	end

endmodule

`default_nettype wire

/* rtl/periodic_hook_scheduler.sv */
// Periodic hook scheduler: a register transaction is answered in the cycle after acceptance.
// A tick or poll rotates the whole channel chain once through the head update unit,
// one slot per cycle while m_tready does not stall the output, then a closing state.
// A register insert is written into the chain when it is accepted, with no walk.
// Reset (arst_n low) empties the table and the output; slot contents are not cleared.
// Depends on phs_pkg, phs_cell, phs_update.
`default_nettype none

module periodic_hook_scheduler import phs_pkg::*; #(
	parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	// [7:0] new_id, [22:8] new_period, [37:23] new_count, [38] new_looped,
	// [39] new_on_tick, [40] new_enabled, [47:41] zero
	input  wire logic [S_DATA_W-1:0] s_tdata,
	// [1:0] command
	input  wire logic [1:0]          s_tuser,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	// [7:0] fired_id, [8] fired, [9] late_warning, [10] overrun_error,
	// [11] table_full, [15:12] zero
	output logic [M_DATA_W-1:0]      m_tdata,
	output logic                     m_tlast
);

	localparam int UW = $clog2(MAX_SLOTS + 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_WALK = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t            state_q;
	logic [UW-1:0]     used_q;
	logic [UW-1:0]     step_q;
	logic              tick_q;
	logic [NRES_W-1:0] nres_q;

	logic              pend_v_q;
	logic [7:0]        pend_id_q;
	logic              pend_warn_q;
	logic              pend_err_q;

	logic              m_tvalid_q;
	logic [7:0]        o_id_q;
	logic              o_fired_q;
	logic              o_warn_q;
	logic              o_err_q;
	logic              o_full_q;
	logic              o_last_q;

	cmd_t        cmd;
	slot_t       new_slot;
	slot_t       chain [MAX_SLOTS];
	logic        ins_chain [MAX_SLOTS];
	slot_t       head_nxt;
	fire_info_t  info;
	cell_ctrl_t  ctrl;

	logic out_free, acc, step, rec, full, last_step;
	logic load_out;
	logic [7:0] ld_id;
	logic ld_fired, ld_warn, ld_err, ld_full, ld_last;

	assign cmd              = cmd_t'(s_tuser);
	assign new_slot.ident   = s_tdata[7:0];
	assign new_slot.period  = s_tdata[22:8];
	assign new_slot.count   = $signed({1'b0, s_tdata[37:23]});
	assign new_slot.looped  = s_tdata[38];
	assign new_slot.on_tick = s_tdata[39];
	assign new_slot.enabled = s_tdata[40];

	assign out_free  = !m_tvalid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE) && out_free;
	assign acc       = s_tvalid && s_tready;
	assign full      = (used_q == UW'(MAX_SLOTS));
	assign step      = (state_q == ST_WALK) && out_free;
	assign last_step = (step_q == used_q - UW'(1));
	assign rec       = step && info.fire && (nres_q < NRES_W'(MAX_RESULTS));

	assign ctrl.rotate = step;
	assign ctrl.insert = acc && (cmd == CMD_REG) && !full;

	for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
		slot_t left_s, right_s;
		logic  left_i;
		if (i == 0) begin : g_first
			assign left_s = new_slot;
			assign left_i = 1'b0;
		end else begin : g_mid
			assign left_s = chain[i-1];
			assign left_i = ins_chain[i-1];
		end
		if (i == MAX_SLOTS - 1) begin : g_last
			assign right_s = head_nxt;
		end else begin : g_inner
			assign right_s = chain[i+1];
		end
		phs_cell #(
			.MAX_SLOTS(MAX_SLOTS),
			.IDX      (i)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.used      (used_q),
			.new_slot  (new_slot),
			.left_slot (left_s),
			.left_ins  (left_i),
			.right_slot(right_s),
			.tail_slot (head_nxt),
			.slot      (chain[i]),
			.ins_here  (ins_chain[i])
		);
	end

	phs_update u_update (
		.head   (chain[0]),
		.is_tick(tick_q),
		.nxt    (head_nxt),
		.info   (info)
	);

	// what goes into the output register this cycle
	always_comb begin
		load_out = 1'b0;
		ld_id    = '0;
		ld_fired = 1'b0;
		ld_warn  = 1'b0;
		ld_err   = 1'b0;
		ld_full  = 1'b0;
		ld_last  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (acc && !(((cmd == CMD_TICK) || (cmd == CMD_POLL)) && (used_q != '0))) begin
					load_out = 1'b1;
					ld_full  = (cmd == CMD_REG) && full;
					ld_last  = 1'b1;
				end
			end
			ST_WALK: begin
				// a held result goes out once a later one proves it is not the last
				if (rec && pend_v_q) begin
					load_out = 1'b1;
					ld_id    = pend_id_q;
					ld_fired = 1'b1;
					ld_warn  = pend_warn_q;
					ld_err   = pend_err_q;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					load_out = 1'b1;
					ld_id    = pend_v_q ? pend_id_q : 8'd0;
					ld_fired = pend_v_q;
					ld_warn  = pend_v_q && pend_warn_q;
					ld_err   = pend_v_q && pend_err_q;
					ld_last  = 1'b1;
				end
			end
			default: begin
				load_out = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			used_q     <= '0;
			step_q     <= '0;
			tick_q     <= 1'b0;
			nres_q     <= '0;
			pend_v_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (ctrl.insert) begin
						used_q <= used_q + UW'(1);
					end
					if (acc && ((cmd == CMD_TICK) || (cmd == CMD_POLL)) && (used_q != '0)) begin
						state_q  <= ST_WALK;
						tick_q   <= (cmd == CMD_TICK);
						step_q   <= '0;
						nres_q   <= '0;
						pend_v_q <= 1'b0;
					end
				end
				ST_WALK: begin
					if (step) begin
						step_q <= step_q + UW'(1);
						if (rec) begin
							pend_v_q <= 1'b1;
							nres_q   <= nres_q + NRES_W'(1);
						end
						if (last_step) begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q  <= ST_IDLE;
						pend_v_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rec) begin
			pend_id_q   <= chain[0].ident;
			pend_warn_q <= info.warn;
			pend_err_q  <= info.err;
		end
		if (load_out) begin
			o_id_q    <= ld_id;
			o_fired_q <= ld_fired;
			o_warn_q  <= ld_warn;
			o_err_q   <= ld_err;
			o_full_q  <= ld_full;
			o_last_q  <= ld_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = o_last_q;
	assign m_tdata  = {4'd0, o_full_q, o_err_q, o_warn_q, o_fired_q, o_id_q};

	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= UW'(MAX_SLOTS))
		else $error("channel count beyond table size");

	a_walk_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (used_q != '0) && (step_q < used_q))
		else $error("walk on empty table or past its end");

	a_pend_counted: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> (nres_q != '0) && (nres_q <= NRES_W'(MAX_RESULTS)))
		else $error("held result without a result count");

	a_fin_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) && out_free |=> m_tvalid && m_tlast)
		else $error("walk ended without a closing result");

endmodule

`default_nettype wire
